// ===== hdl/trpg_pkg.sv =====
package trpg_pkg;

  localparam int unsigned START_PULSES = 4;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SINGLE = 2'd1,
    OP_TIMED  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_HALF_PERIOD = 2'd0,
    REG_CMD_REPEATS = 2'd1,
    REG_END_REPEATS = 2'd2,
    REG_END_PULSES  = 2'd3
  } reg_idx_t;

  localparam logic [15:0] HALF_PERIOD_RST = 16'd500;
  localparam logic [7:0]  CMD_REPEATS_RST = 8'd1;
  localparam logic [7:0]  END_REPEATS_RST = 8'd1;
  localparam logic [6:0]  END_PULSES_RST  = 7'd4;

  typedef struct packed {
    logic signal_level;
    logic power_on;
    logic busy_res;
    logic done_res;
  } res_t;

endpackage

// ===== hdl/toy_remote_pulse_train_generator_top.sv =====
// Toy remote pulse train generator. Send one transaction per microsecond tick
// (operation 0) and a start (1 single burst, 2 timed bursts) when idle; every
// transaction yields exactly one result. An input transaction is taken in the
// cycle it is offered unless stalled, so one transaction per clock is sustained;
// the state update is a single registered pass. A two-entry output buffer
// (result register plus skid register) lets input continue while one result
// waits; input stalls only once both entries hold results. Configuration writes
// take effect on the next clock and should be made while no sequence runs.
module toy_remote_pulse_train_generator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [6:0]  function_pulses,
  input  logic [31:0] duration_us,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        signal_level,
  output logic        power_on,
  output logic        busy_res,
  output logic        done_res
);

  trpg_pkg::res_t res_new;
  trpg_pkg::res_t res_out;
  trpg_pkg::res_t res_skid;
  logic           skid_valid;
  logic           accept;
  logic           out_move;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign out_move = out_valid && !out_stall;

  trpg_engine u_engine (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .step            (accept),
    .operation       (operation),
    .function_pulses (function_pulses),
    .duration_us     (duration_us),
    .res             (res_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_move) begin
        res_out    <= res_skid;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid || out_move) begin
        res_out   <= res_new;
        out_valid <= 1'b1;
      end else begin
        res_skid   <= res_new;
        skid_valid <= 1'b1;
      end
    end else if (out_move) begin
      out_valid <= 1'b0;
    end
  end

  assign signal_level = res_out.signal_level;
  assign power_on     = res_out.power_on;
  assign busy_res     = res_out.busy_res;
  assign done_res     = res_out.done_res;

endmodule

// ===== hdl/trpg_engine.sv =====
module trpg_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               step,
  input  logic [1:0]         operation,
  input  logic [6:0]         function_pulses,
  input  logic [31:0]        duration_us,
  output trpg_pkg::res_t     res
);

  typedef struct packed {
    logic        active;
    logic        timed;
    logic        in_end;
    logic        in_func;
    logic        phase;
    logic [15:0] timer;
    logic [1:0]  hidx;
    logic [6:0]  pidx;
    logic [7:0]  widx;
    logic [6:0]  latched;
    logic [31:0] elapsed;
    logic [31:0] target;
  } st_t;

  st_t st, st_next;

  logic [15:0] half_period_us;
  logic [7:0]  command_word_repeats;
  logic [7:0]  end_word_repeats;
  logic [6:0]  end_code_pulses;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_us       <= trpg_pkg::HALF_PERIOD_RST;
      command_word_repeats <= trpg_pkg::CMD_REPEATS_RST;
      end_word_repeats     <= trpg_pkg::END_REPEATS_RST;
      end_code_pulses      <= trpg_pkg::END_PULSES_RST;
    end else if (cfg_wr_en) begin
      unique case (trpg_pkg::reg_idx_t'(cfg_index))
        trpg_pkg::REG_HALF_PERIOD: half_period_us       <= cfg_data;
        trpg_pkg::REG_CMD_REPEATS: command_word_repeats <= cfg_data[7:0];
        trpg_pkg::REG_END_REPEATS: end_word_repeats     <= cfg_data[7:0];
        trpg_pkg::REG_END_PULSES:  end_code_pulses      <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step) begin
      st <= st_next;
    end
  end

  always_comb begin
    logic        fw;
    logic        bw;
    logic        bb;
    logic        chk_end;
    logic        empty;
    logic        more_time;
    logic        done;
    logic [15:0] h;
    logic [1:0]  halves;
    logic [6:0]  cnt;

    st_next   = st;
    fw        = 1'b0;
    bw        = 1'b0;
    bb        = 1'b0;
    chk_end   = 1'b0;
    done      = 1'b0;
    empty     = (command_word_repeats == 8'd0) && (end_word_repeats == 8'd0);
    h         = (half_period_us == 16'd0) ? 16'd1 : half_period_us;
    halves    = (st.phase && !st.in_func) ? 2'd3 : 2'd1;
    cnt       = st.in_end ? end_code_pulses : st.latched;
    more_time = 1'b0;

    if (operation == trpg_pkg::OP_TICK) begin
      if (st.active) begin
        if (st.elapsed != 32'hFFFF_FFFF) begin
          st_next.elapsed = st.elapsed + 32'd1;
        end
        if (({1'b0, st.timer} + 17'd1) >= {1'b0, h}) begin
          st_next.timer = '0;
          st_next.hidx  = st.hidx + 2'd1;
          if (st_next.hidx >= halves) begin
            st_next.hidx = '0;
            if (st.phase) begin
              st_next.phase = 1'b0;
            end else begin
              st_next.pidx = st.pidx + 7'd1;
              if (!st.in_func) begin
                if (st_next.pidx < 7'(trpg_pkg::START_PULSES)) begin
                  st_next.phase = 1'b1;
                end else begin
                  st_next.in_func = 1'b1;
                  st_next.pidx    = '0;
                  if (cnt == 7'd0) fw = 1'b1;
                  else st_next.phase = 1'b1;
                end
              end else if (st_next.pidx >= cnt) begin
                fw = 1'b1;
              end else begin
                st_next.phase = 1'b1;
              end
            end
          end
        end else begin
          st_next.timer = st.timer + 16'd1;
        end
      end
      more_time = st.timed && (st_next.elapsed < st.target);
      if (fw) begin
        st_next.widx = st.widx + 8'd1;
        chk_end      = 1'b1;
        if (!st.in_end) begin
          if (st_next.widx < command_word_repeats) begin
            bw      = 1'b1;
            chk_end = 1'b0;
          end else begin
            st_next.in_end = 1'b1;
            st_next.widx   = '0;
          end
        end
        if (chk_end) begin
          if (st_next.widx < end_word_repeats) begin
            bw = 1'b1;
          end else if (more_time && !empty) begin
            bb = 1'b1;
          end else begin
            if (more_time) begin
              st_next.in_end = 1'b1;
              st_next.widx   = '0;
            end
            st_next.active = 1'b0;
            done           = 1'b1;
          end
        end
      end
      if (bb) begin
        st_next.in_end = (command_word_repeats == 8'd0);
        st_next.widx   = '0;
        bw             = 1'b1;
      end
    end else if ((operation == trpg_pkg::OP_SINGLE || operation == trpg_pkg::OP_TIMED)
                 && !st.active) begin
      st_next.timed   = (operation == trpg_pkg::OP_TIMED);
      st_next.latched = function_pulses;
      st_next.target  = duration_us;
      st_next.elapsed = '0;
      if (st_next.timed && duration_us == 32'd0) begin
        st_next.active = 1'b0;
        done           = 1'b1;
      end else begin
        st_next.in_end = (command_word_repeats == 8'd0);
        st_next.widx   = '0;
        if (empty) begin
          st_next.active = 1'b0;
          done           = 1'b1;
        end else begin
          st_next.active = 1'b1;
          bw             = 1'b1;
        end
      end
    end

    if (bw) begin
      st_next.in_func = 1'b0;
      st_next.pidx    = '0;
      st_next.phase   = 1'b1;
      st_next.timer   = '0;
      st_next.hidx    = '0;
    end

    if (operation == trpg_pkg::OP_TICK) begin
      res.signal_level = st.active && st.phase;
      res.power_on     = st.active;
      res.busy_res     = st.active;
    end else begin
      res.signal_level = st_next.active && st_next.phase;
      res.power_on     = st_next.active;
      res.busy_res     = st_next.active;
    end
    res.done_res = done;
  end

endmodule

// ===== hdl/trpg_checker.sv =====
module trpg_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        signal_level,
  input logic        power_on,
  input logic        busy_res,
  input logic        done_res
);

  a_power_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (power_on == busy_res))
    else $error("power_on and busy_res differ");

  a_level_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && signal_level) |-> busy_res)
    else $error("signal high while not busy");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(signal_level)
                                  && $stable(done_res)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind toy_remote_pulse_train_generator_top trpg_checker u_chk (.*);
